@@ design/line_sharing_profiler_macros.svh @@
// Assertion macros used by the profiler datapath.
`ifndef LINE_SHARING_PROFILER_MACROS_SVH
`define LINE_SHARING_PROFILER_MACROS_SVH

// Checked only outside reset.
`define LSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsp assertion failed");

// Checked on every edge, reset included.
`define LSP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lsp assertion failed");

`endif

@@ design/lsp_pkg.sv @@
// Types and constants of the line sharing profiler.
`timescale 1ns / 1ps
package lsp_pkg;

  localparam logic [1:0] CLS_PRIVATE   = 2'd0;
  localparam logic [1:0] CLS_MIGRATE   = 2'd1;
  localparam logic [1:0] CLS_SHARED_RO = 2'd2;
  localparam logic [1:0] CLS_SHARED_RW = 2'd3;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_PRIV_SRW = 2'd1;
  localparam logic [1:0] KIND_SRW_PRIV = 2'd2;
  localparam logic [1:0] KIND_SRW_SRW  = 2'd3;

  typedef struct packed {
    logic [31:0] line_address;
    logic [7:0]  read_count;
    logic [7:0]  write_count;
    logic [7:0]  word_count;
    logic [1:0]  share_class;
    logic [5:0]  owner_core;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [9:0]  entry_index;
    logic        recorded;
    logic        table_full;
    logic [1:0]  merged_class;
    logic        class_changed;
    logic [1:0]  transition_kind;
    logic [6:0]  bin_index;
    logic [31:0] bin_count;
  } out_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic out_busy;
  } ctl_sts_t;

endpackage

@@ design/line_sharing_profiler.sv @@
// Top level of the cache-line sharing profiler.
// One residency record in, one result beat out per record. After reset the class
// histogram memory is cleared before the first record is taken. For each record the tag
// memory is scanned one entry per cycle through its single read port over the lines
// already in the table, then the entry class and histogram bin are read, merged and
// written back. A finished result waits in an output register while the next record is
// taken.
`timescale 1ns / 1ps
module line_sharing_profiler #(
  parameter int TABLE_DEPTH = 1024,
  parameter int BIN_CAP     = 100,
  parameter int ADDR_BITS   = 32,
  parameter int OWNER_BITS  = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lsp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lsp_pkg::out_t out_data_o
);
  lsp_pkg::ctl_cmd_t cmd;
  lsp_pkg::ctl_sts_t sts;

  lsp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  lsp_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH), .BIN_CAP(BIN_CAP),
    .ADDR_BITS(ADDR_BITS), .OWNER_BITS(OWNER_BITS)
  ) u_datapath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule

@@ design/lsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ design/lsp_ctrl.sv @@
// Sequencing state machine of the profiler.
`timescale 1ns / 1ps
module lsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lsp_pkg::ctl_sts_t sts_i,
  output lsp_pkg::ctl_cmd_t cmd_o
);
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_LOOK   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end
endmodule

@@ design/lsp_datapath.sv @@
// Tag scan, entry merge and histogram update of the profiler.
`timescale 1ns / 1ps
`include "line_sharing_profiler_macros.svh"
module lsp_datapath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int BIN_CAP     = 100,
  parameter int ADDR_BITS   = 32,
  parameter int OWNER_BITS  = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsp_pkg::ctl_cmd_t cmd_i,
  output lsp_pkg::ctl_sts_t sts_o,
  input  lsp_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lsp_pkg::out_t     out_data_o
);
  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int FILL_W     = $clog2(TABLE_DEPTH + 1);
  localparam int BIN_W      = $clog2(BIN_CAP + 1);
  localparam int HIST_DEPTH = 4 * (BIN_CAP + 1);
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CLR_W      = $clog2(HIST_DEPTH + 1);
  localparam int META_W     = 2 + OWNER_BITS;
  localparam logic [FILL_W-1:0]  FILL_MAX = FILL_W'(TABLE_DEPTH);
  localparam logic [CLR_W-1:0]   CLR_END  = CLR_W'(HIST_DEPTH);
  localparam logic [HIST_AW-1:0] ROW_LEN  = HIST_AW'(BIN_CAP + 1);
  localparam logic [8:0]         CAP9     = 9'(BIN_CAP);

  lsp_pkg::in_t    item_q;
  lsp_pkg::out_t   out_q, res;
  logic            out_valid_q;
  logic [CLR_W-1:0]  clr_q;
  logic [FILL_W-1:0] fill_q, scan_q;
  logic              pend_q, hit_q;
  logic [IDX_W-1:0]  pidx_q, idx_q;

  logic [ADDR_BITS-1:0]  tag, tag_rdata;
  logic [OWNER_BITS-1:0] own;
  logic [META_W-1:0]     meta_rdata, meta_wdata;
  logic [31:0]           hist_rdata, hist_new;
  logic [HIST_AW-1:0]    hist_addr, hist_waddr;
  logic [31:0]           hist_wdata;
  logic                  hist_we;
  logic [8:0]            sum9;
  logic [BIN_W-1:0]      bin;
  logic                  found, active, full, alloc, rec;
  logic [1:0]            old_cls, new_cls, merged;
  logic [OWNER_BITS-1:0] old_own;

  assign tag = ADDR_BITS'(item_q.line_address);
  assign own = OWNER_BITS'(item_q.owner_core);
  assign sum9 = {1'b0, item_q.read_count} + {1'b0, item_q.write_count};
  assign bin = (sum9 > CAP9) ? BIN_W'(CAP9) : BIN_W'(sum9);
  assign hist_addr = HIST_AW'(item_q.share_class) * ROW_LEN + HIST_AW'(bin);

  assign found = pend_q && (tag_rdata == tag);
  assign sts_o.clear_done = (clr_q == CLR_END);
  assign sts_o.scan_done  = found || (scan_q >= fill_q);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  lsp_ram #(.WIDTH(ADDR_BITS), .DEPTH(TABLE_DEPTH)) u_tag_ram (
    .clk_i, .we_i(cmd_i.commit && alloc), .waddr_i(idx_q), .wdata_i(tag),
    .raddr_i(scan_q[IDX_W-1:0]), .rdata_o(tag_rdata)
  );

  assign meta_wdata = {merged, own};
  lsp_ram #(.WIDTH(META_W), .DEPTH(TABLE_DEPTH)) u_meta_ram (
    .clk_i, .we_i(cmd_i.commit && rec), .waddr_i(idx_q), .wdata_i(meta_wdata),
    .raddr_i(idx_q), .rdata_o(meta_rdata)
  );

  assign hist_new   = (&hist_rdata) ? hist_rdata : hist_rdata + 32'd1;
  assign hist_we    = cmd_i.clear_step ? !sts_o.clear_done : (cmd_i.commit && rec);
  assign hist_waddr = cmd_i.clear_step ? clr_q[HIST_AW-1:0] : hist_addr;
  assign hist_wdata = cmd_i.clear_step ? 32'd0 : hist_new;
  lsp_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk_i, .we_i(hist_we), .waddr_i(hist_waddr), .wdata_i(hist_wdata),
    .raddr_i(hist_addr), .rdata_o(hist_rdata)
  );

  // merge of stored and incoming class, highest priority first
  assign old_cls = meta_rdata[META_W-1:OWNER_BITS];
  assign old_own = meta_rdata[OWNER_BITS-1:0];
  assign new_cls = item_q.share_class;
  assign active  = |{item_q.read_count, item_q.write_count, item_q.word_count};
  assign full    = !hit_q && (fill_q >= FILL_MAX);
  assign alloc   = !hit_q && active && !full;
  assign rec     = active && (hit_q || !full);

  always_comb begin
    if (!hit_q) merged = new_cls;
    else if (old_cls == lsp_pkg::CLS_SHARED_RW || new_cls == lsp_pkg::CLS_SHARED_RW)
      merged = lsp_pkg::CLS_SHARED_RW;
    else if (old_cls == lsp_pkg::CLS_SHARED_RO || new_cls == lsp_pkg::CLS_SHARED_RO)
      merged = lsp_pkg::CLS_SHARED_RO;
    else if (old_cls == lsp_pkg::CLS_MIGRATE || old_own != own)
      merged = lsp_pkg::CLS_MIGRATE;
    else merged = lsp_pkg::CLS_PRIVATE;
  end

  always_comb begin
    res = '0;
    res.hit = hit_q;
    res.entry_index = (hit_q || alloc) ? 10'(idx_q) : 10'd0;
    res.recorded = rec;
    res.table_full = active && full;
    if (hit_q) res.merged_class = active ? merged : old_cls;
    else if (alloc) res.merged_class = new_cls;
    if (hit_q && active) begin
      res.class_changed = (merged != old_cls);
      if (old_cls == lsp_pkg::CLS_SHARED_RW && new_cls == lsp_pkg::CLS_SHARED_RW)
        res.transition_kind = lsp_pkg::KIND_SRW_SRW;
      else if (merged == lsp_pkg::CLS_SHARED_RW && old_cls == lsp_pkg::CLS_PRIVATE)
        res.transition_kind = lsp_pkg::KIND_PRIV_SRW;
      else if (merged == lsp_pkg::CLS_SHARED_RW && new_cls == lsp_pkg::CLS_PRIVATE)
        res.transition_kind = lsp_pkg::KIND_SRW_PRIV;
    end
    if (rec) begin
      res.bin_index = 7'(bin);
      res.bin_count = hist_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      fill_q <= '0;
      scan_q <= '0;
      pend_q <= 1'b0;
      hit_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step && !sts_o.clear_done) clr_q <= clr_q + CLR_W'(1);
      if (cmd_i.accept) begin
        scan_q <= '0;
        pend_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (sts_o.scan_done) begin
          hit_q <= found;
        end else begin
          pend_q <= 1'b1;
          scan_q <= scan_q + FILL_W'(1);
        end
      end
      if (cmd_i.commit && alloc) fill_q <= fill_q + FILL_W'(1);
      if (cmd_i.commit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_data_i;
    if (cmd_i.scan) begin
      pidx_q <= scan_q[IDX_W-1:0];
      if (sts_o.scan_done) idx_q <= found ? pidx_q : fill_q[IDX_W-1:0];
    end
    if (cmd_i.commit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LSP_ASSERT(a_fill_bound, fill_q <= FILL_MAX)
  `LSP_ASSERT(a_full_not_rec, out_valid_q |-> !(out_q.table_full && out_q.recorded))
  `LSP_ASSERT(a_alloc_fill, (cmd_i.commit && alloc) |=> fill_q == $past(fill_q) + FILL_W'(1))
endmodule
